// ===== sv/ima_adpcm_nibble_decoder_unit_macros.svh =====
// ---------------------------------------------------------------------------
// ima_adpcm_nibble_decoder_unit_macros
// assertion macros for the adpcm decoder
// ---------------------------------------------------------------------------
`ifndef IMA_ADPCM_NIBBLE_DECODER_UNIT_MACROS_SVH
`define IMA_ADPCM_NIBBLE_DECODER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IMAD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IMAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/imad_pkg.sv =====
// ---------------------------------------------------------------------------
// imad_pkg
// types, constants and tables of the adpcm decoder
// ---------------------------------------------------------------------------
package imad_pkg;

  typedef enum logic {
    ACT_DECODE = 1'b0,
    ACT_LOAD   = 1'b1
  } act_t;

  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } imad_state_t;

  localparam logic [6:0]          IdxMax  = 7'd88;
  localparam logic signed [17:0]  PredMax = 18'sd32767;
  localparam logic signed [17:0]  PredMin = -18'sd32768;

  localparam logic signed [4:0] IndexAdjust [8] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/imad_nibble_step.sv =====
// ---------------------------------------------------------------------------
// imad_nibble_step
// one adpcm nibble: step lookup, difference, saturating predictor, index move
// ---------------------------------------------------------------------------
module imad_nibble_step
  import imad_pkg::*;
(
  input  imad_state_t cur,
  input  logic [3:0]  nib,
  output imad_state_t nxt
);

  logic [14:0]        step;
  logic [15:0]        diff;
  logic signed [17:0] pred_ext;
  logic signed [17:0] diff_ext;
  logic signed [17:0] sum;
  logic signed [7:0]  idx_sum;

  always_comb begin
    step = step_size(cur.idx);
    diff = {4'd0, step[14:3]};
    if (nib[2]) diff = diff + {1'b0, step};
    if (nib[1]) diff = diff + {2'd0, step[14:1]};
    if (nib[0]) diff = diff + {3'd0, step[14:2]};

    pred_ext = {{2{cur.pred[15]}}, cur.pred};
    diff_ext = {2'b00, diff};
    sum = nib[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

    if (sum > PredMax) nxt.pred = PredMax[15:0];
    else if (sum < PredMin) nxt.pred = PredMin[15:0];
    else nxt.pred = sum[15:0];

    idx_sum = $signed({1'b0, cur.idx}) + {{3{IndexAdjust[nib[2:0]][4]}},
                                          IndexAdjust[nib[2:0]]};
    if (idx_sum < 8'sd0) nxt.idx = 7'd0;
    else if (idx_sum > $signed({1'b0, IdxMax})) nxt.idx = IdxMax;
    else nxt.idx = idx_sum[6:0];
  end

endmodule

// ===== sv/ima_adpcm_nibble_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// ima_adpcm_nibble_decoder_unit
// ima adpcm decoder: header load and two-nibble byte decode
// ---------------------------------------------------------------------------
// flow: requests are held in the s_ registers and samples are registered at the
//   output; a decode emits its second sample after its first
// rate: a load request every cycle, one nibble step a cycle (shared datapath),
//   unless the output stalls; a decode frees input when its second nibble goes
// reset: predictor, step index and all valid flags clear to zero
module ima_adpcm_nibble_decoder_unit
  import imad_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [7:0]         code_byte,
  input  logic signed [15:0] header_predictor,
  input  logic [6:0]         header_index,
  input  logic               block_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               run_last,
  output logic               block_end
);

`include "ima_adpcm_nibble_decoder_unit_macros.svh"

  imad_state_t        state;
  imad_state_t        state_next;
  imad_state_t        step_out;

  logic               s_valid;
  logic               s_phase;
  act_t               s_action;
  logic [7:0]         s_code;
  logic signed [15:0] s_pred;
  logic [6:0]         s_idx;
  logic               s_last;

  logic               emit;
  logic               item_done;
  logic               in_take;
  logic [3:0]         nib;

  assign emit      = s_valid && (!out_valid || out_ready);
  assign item_done = (s_action == ACT_LOAD) || s_phase;
  assign in_ready  = !s_valid || (emit && item_done);
  assign in_take   = in_valid && in_ready;
  assign nib       = s_phase ? s_code[7:4] : s_code[3:0];

  imad_nibble_step u_step (
    .cur (state),
    .nib (nib),
    .nxt (step_out)
  );

  always_comb begin
    if (s_action == ACT_LOAD) begin
      state_next.pred = s_pred;
      state_next.idx  = (s_idx > IdxMax) ? IdxMax : s_idx;
    end else begin
      state_next = step_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      s_phase   <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (in_take) begin
        s_valid <= 1'b1;
        s_phase <= 1'b0;
      end else if (emit) begin
        if (item_done) s_valid <= 1'b0;
        else s_phase <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_action <= act_t'(action);
      s_code   <= code_byte;
      s_pred   <= header_predictor;
      s_idx    <= header_index;
      s_last   <= block_last;
    end
    if (emit) begin
      sample    <= state_next.pred;
      run_last  <= item_done;
      block_end <= (s_action == ACT_DECODE) && s_phase && s_last;
    end
  end

  `IMAD_ASSERT_SAME(a_idx_range, 1'b1, state.idx <= IdxMax, "step index above 88")
  `IMAD_ASSERT_NEXT(a_second_nibble, emit && !item_done, s_valid && s_phase,
                    "second nibble not pending after first")
  `IMAD_ASSERT_SAME(a_end_is_last, out_valid && block_end, run_last,
                    "block end without run last")

endmodule
